/* rtl/mpsm_pkg.sv */
// Shared types for the multi-pattern string matcher: operation codes and the
// command and status groups between the controller and the datapath. No dependencies.
`default_nettype none

package mpsm_pkg;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_TRANS  = 3'd1,
        OP_FAIL   = 3'd2,
        OP_OUTPUT = 3'd3,
        OP_FINISH = 3'd4,
        OP_SCAN   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        RES_PLAIN  = 2'd0,
        RES_REJECT = 2'd1,
        RES_SCAN   = 2'd2,
        RES_ZERO   = 2'd3
    } res_kind_t;

    typedef struct packed {
        logic      capture;
        logic      clear_regs;
        logic      goto_wr;
        logic      fail_wr;
        logic      out_wr;
        logic      set_ready;
        logic      rd_root;
        logic      latch_root;
        logic      hop;
        logic      resolve;
        logic      accumulate;
        logic      res_load;
        res_kind_t res_kind;
        logic      out_load;
        logic      sweep;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic tables_ready;
        logic hit;
        logic stop;
        logic sweep_last;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

/* rtl/mpsm_dpath.sv */
// Datapath of the matcher: transition, failure and output-set memories, the walk
// registers, the result register and the output register. Uses mpsm_pkg.
`default_nettype none

module mpsm_dpath #(
    parameter int STATE_COUNT   = 256,
    parameter int PATTERN_COUNT = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mpsm_pkg::cmd_t    cmd,
    output mpsm_pkg::stat_t        stat,
    input  wire logic [2:0]        s_operation,
    input  wire logic [7:0]        s_from_state,
    input  wire logic [7:0]        s_symbol,
    input  wire logic [7:0]        s_to_state,
    input  wire logic [5:0]        s_pattern_index,
    input  wire logic              s_last_symbol,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_status,
    output logic [63:0]            m_match_mask,
    output logic                   m_scan_done,
    output logic [7:0]             m_current_state
);

    localparam int NS   = (STATE_COUNT < 256) ? STATE_COUNT : 256;
    localparam int SW   = $clog2(NS);
    localparam int GD   = NS * 256;
    localparam int GAW  = SW + 8;
    localparam int HW   = $clog2(STATE_COUNT + 1);
    localparam int PC   = PATTERN_COUNT;
    localparam int CMPW = 13;

    logic [SW:0]    goto_mem [GD];
    logic [SW-1:0]  fail_mem [NS];
    logic [PC-1:0]  out_mem  [NS];

    logic [SW:0]    goto_rd_reg;
    logic [SW-1:0]  fail_rd_reg;
    logic [PC-1:0]  out_rd_reg;

    mpsm_pkg::op_t  op_reg;
    logic [7:0]     from_reg, sym_reg, to_reg;
    logic [5:0]     pat_reg;
    logic           last_reg;

    logic           ready_reg;
    logic [SW-1:0]  active_reg;
    logic [PC-1:0]  acc_reg;
    logic [SW-1:0]  walk_reg;
    logic [HW-1:0]  hops_reg;
    logic           root_valid_reg;
    logic [GAW-1:0] sweep_cnt_reg;

    logic           res_status_reg, res_done_reg;
    logic [PC-1:0]  res_mask_reg;
    logic [SW-1:0]  res_state_reg;

    logic           m_valid_reg, m_status_reg, m_done_reg;
    logic [PC-1:0]  m_mask_reg;
    logic [SW-1:0]  m_state_reg;

    logic           from_ok, to_ok, pat_ok, hit, stop, sweep_low;
    logic [SW-1:0]  from_s, s_new, next_s, goto_s, out_raddr;
    logic [HW-1:0]  hops_next;
    logic [PC-1:0]  acc_new, pat_bit;

    assign from_ok   = {5'b0, from_reg} < CMPW'(STATE_COUNT);
    assign to_ok     = {5'b0, to_reg} < CMPW'(STATE_COUNT);
    assign pat_ok    = {1'b0, pat_reg} < 7'(PATTERN_COUNT);
    assign from_s    = from_reg[SW-1:0];
    assign pat_bit   = PC'(1) << pat_reg;
    assign hit       = goto_rd_reg[SW];
    assign stop      = (walk_reg == '0) || !root_valid_reg;
    assign next_s    = hit ? goto_rd_reg[SW-1:0] : '0;
    assign hops_next = hops_reg + HW'(1);
    // After as many hops as there are states the walk restarts from the root.
    assign s_new     = (hops_next == HW'(STATE_COUNT)) ? '0 : fail_rd_reg;
    assign goto_s    = cmd.rd_root ? '0 : (cmd.hop ? s_new : walk_reg);
    assign out_raddr = cmd.resolve ? next_s : from_s;
    assign acc_new   = acc_reg | out_rd_reg;
    assign sweep_low = sweep_cnt_reg < GAW'(NS);

    always_ff @(posedge aclk) begin
        if (cmd.sweep) begin
            goto_mem[sweep_cnt_reg] <= '0;
        end else if (cmd.goto_wr && from_ok && to_ok) begin
            goto_mem[{from_s, sym_reg}] <= {1'b1, to_reg[SW-1:0]};
        end
        goto_rd_reg <= goto_mem[{goto_s, sym_reg}];
    end

    always_ff @(posedge aclk) begin
        if (cmd.sweep && sweep_low) begin
            fail_mem[sweep_cnt_reg[SW-1:0]] <= '0;
        end else if (cmd.fail_wr && from_ok && to_ok) begin
            fail_mem[from_s] <= to_reg[SW-1:0];
        end
        fail_rd_reg <= fail_mem[goto_s];
    end

    always_ff @(posedge aclk) begin
        if (cmd.sweep && sweep_low) begin
            out_mem[sweep_cnt_reg[SW-1:0]] <= '0;
        end else if (cmd.out_wr && from_ok && pat_ok) begin
            out_mem[from_s] <= out_rd_reg | pat_bit;
        end
        out_rd_reg <= out_mem[out_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= mpsm_pkg::op_t'(s_operation);
            from_reg <= s_from_state;
            sym_reg  <= s_symbol;
            to_reg   <= s_to_state;
            pat_reg  <= s_pattern_index;
            last_reg <= s_last_symbol;
            walk_reg <= active_reg;
            hops_reg <= '0;
        end else if (cmd.hop) begin
            walk_reg <= s_new;
            hops_reg <= hops_next;
        end else if (cmd.resolve) begin
            walk_reg <= next_s;
        end
        if (cmd.latch_root) begin
            root_valid_reg <= hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_regs) begin
            ready_reg  <= 1'b0;
            active_reg <= '0;
            acc_reg    <= '0;
        end else begin
            if (cmd.set_ready) begin
                ready_reg <= 1'b1;
            end
            if (cmd.accumulate) begin
                active_reg <= last_reg ? '0 : walk_reg;
                acc_reg    <= last_reg ? '0 : acc_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_cnt_reg <= '0;
        end else if (cmd.sweep) begin
            sweep_cnt_reg <= (sweep_cnt_reg == GAW'(GD - 1)) ? '0 : sweep_cnt_reg + GAW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            case (cmd.res_kind)
                mpsm_pkg::RES_PLAIN: begin
                    res_status_reg <= 1'b0;
                    res_mask_reg   <= acc_reg;
                    res_done_reg   <= 1'b0;
                    res_state_reg  <= active_reg;
                end
                mpsm_pkg::RES_REJECT: begin
                    res_status_reg <= 1'b1;
                    res_mask_reg   <= '0;
                    res_done_reg   <= 1'b0;
                    res_state_reg  <= active_reg;
                end
                mpsm_pkg::RES_SCAN: begin
                    res_status_reg <= 1'b0;
                    res_mask_reg   <= acc_new;
                    res_done_reg   <= last_reg;
                    res_state_reg  <= last_reg ? '0 : walk_reg;
                end
                default: begin
                    res_status_reg <= 1'b0;
                    res_mask_reg   <= '0;
                    res_done_reg   <= 1'b0;
                    res_state_reg  <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_mask_reg   <= res_mask_reg;
            m_done_reg   <= res_done_reg;
            m_state_reg  <= res_state_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_match_mask    = 64'(m_mask_reg);
    assign m_scan_done     = m_done_reg;
    assign m_current_state = 8'(m_state_reg);

    assign stat.op           = op_reg;
    assign stat.tables_ready = ready_reg;
    assign stat.hit          = hit;
    assign stat.stop         = stop;
    assign stat.sweep_last   = sweep_cnt_reg == GAW'(GD - 1);
    assign stat.out_free     = !m_valid_reg || m_ready;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register loaded while a request is pending");
    a_hop_only_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.hop |-> (!hit && !stop))
        else $error("failure hop taken although the walk had resolved");
    a_done_at_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_done_reg) |-> (m_state_reg == '0))
        else $error("finished text did not return to the root");
    a_reject_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg) |-> (m_mask_reg == '0 && !m_done_reg))
        else $error("rejected scan carries match data");
`endif

endmodule

`default_nettype wire

/* rtl/mpsm_ctrl.sv */
// Controller state machine of the matcher: sequences loads, the failure-link walk,
// result hand-off and the table clearing pass. Uses mpsm_pkg.
`default_nettype none

module mpsm_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire mpsm_pkg::stat_t  stat,
    output mpsm_pkg::cmd_t        cmd
);

    typedef enum logic [7:0] {
        ST_SWEEP  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_EXEC   = 8'b0000_0100,
        ST_OUTWR  = 8'b0000_1000,
        ST_ROOT   = 8'b0001_0000,
        ST_WALK   = 8'b0010_0000,
        ST_ACC    = 8'b0100_0000,
        ST_RESULT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.res_kind = mpsm_pkg::RES_PLAIN;
        case (state_reg)
            ST_SWEEP: begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next   = ST_RESULT;
                cmd.res_load = 1'b1;
                case (stat.op)
                    mpsm_pkg::OP_CLEAR: begin
                        cmd.clear_regs = 1'b1;
                        cmd.res_kind   = mpsm_pkg::RES_ZERO;
                    end
                    mpsm_pkg::OP_TRANS:  cmd.goto_wr = 1'b1;
                    mpsm_pkg::OP_FAIL:   cmd.fail_wr = 1'b1;
                    mpsm_pkg::OP_OUTPUT: state_next = ST_OUTWR;
                    mpsm_pkg::OP_FINISH: cmd.set_ready = 1'b1;
                    mpsm_pkg::OP_SCAN: begin
                        if (stat.tables_ready) begin
                            cmd.res_load = 1'b0;
                            cmd.rd_root  = 1'b1;
                            state_next   = ST_ROOT;
                        end else begin
                            cmd.res_kind = mpsm_pkg::RES_REJECT;
                        end
                    end
                    default: ;
                endcase
            end
            ST_OUTWR: begin
                cmd.out_wr = 1'b1;
                state_next = ST_RESULT;
            end
            ST_ROOT: begin
                cmd.latch_root = 1'b1;
                state_next     = ST_WALK;
            end
            ST_WALK: begin
                if (stat.hit || stat.stop) begin
                    cmd.resolve = 1'b1;
                    state_next  = ST_ACC;
                end else begin
                    cmd.hop = 1'b1;
                end
            end
            ST_ACC: begin
                cmd.accumulate = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_kind   = mpsm_pkg::RES_SCAN;
                state_next     = ST_RESULT;
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = (stat.op == mpsm_pkg::OP_CLEAR) ? ST_SWEEP : ST_IDLE;
                end
            end
            default: state_next = ST_SWEEP;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/multi_pattern_string_matcher.sv */
// A request is executed and its result held until the output register is free; add
// output writes the output set first. A scan with ready tables reads the root, hops
// failure links until a transition hits or the walk stops, then accumulates. A new
// request is taken once the result is in the output register. One hop per cycle
// through the transition memory's single read port sets the scan rate. Reset and
// clear sweep all three memories, input not ready; the clear result is given first.
`default_nettype none

module multi_pattern_string_matcher #(
    parameter int STATE_COUNT   = 256,
    parameter int PATTERN_COUNT = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_operation,
    input  wire logic [7:0]  s_from_state,
    input  wire logic [7:0]  s_symbol,
    input  wire logic [7:0]  s_to_state,
    input  wire logic [5:0]  s_pattern_index,
    input  wire logic        s_last_symbol,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_status,
    output logic [63:0]      m_match_mask,
    output logic             m_scan_done,
    output logic [7:0]       m_current_state
);

    mpsm_pkg::cmd_t  cmd;
    mpsm_pkg::stat_t stat;

    mpsm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mpsm_dpath #(
        .STATE_COUNT   (STATE_COUNT),
        .PATTERN_COUNT (PATTERN_COUNT)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_operation     (s_operation),
        .s_from_state    (s_from_state),
        .s_symbol        (s_symbol),
        .s_to_state      (s_to_state),
        .s_pattern_index (s_pattern_index),
        .s_last_symbol   (s_last_symbol),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_match_mask    (m_match_mask),
        .m_scan_done     (m_scan_done),
        .m_current_state (m_current_state)
    );

endmodule

`default_nettype wire
